/* hw/rtl/sukset_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted unique key set - shared definitions
// Field widths, command and status codes, sequencer states and the
// result record passed from the sequencer to the output stage.
// ----------------------------------------------------------------------------
package sukset_pkg;

   localparam int WORD_W   = 32;
   localparam int KEY_W    = 3 * WORD_W;
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 3;
   localparam int INDEX_W  = 6;
   localparam int TOTAL_W  = 7;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [WORD_W-1:0]   word_type;
   typedef logic [KEY_W-1:0]    key_type;

   // command codes
   localparam cmd_type CMD_CLEAR  = 3'd0;
   localparam cmd_type CMD_INSERT = 3'd1;
   localparam cmd_type CMD_DELETE = 3'd2;
   localparam cmd_type CMD_LOOKUP = 3'd3;
   localparam cmd_type CMD_READ   = 3'd4;

   // status codes
   localparam status_type ST_DONE      = 3'd0;
   localparam status_type ST_DUPLICATE = 3'd1;
   localparam status_type ST_NOT_FOUND = 3'd2;
   localparam status_type ST_FULL      = 3'd3;
   localparam status_type ST_RANGE     = 3'd4;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_READ,
      SEQ_SCAN,
      SEQ_SHIFT,
      SEQ_FINISH
   } seq_state_type;

   typedef struct packed {
      status_type           status;
      logic                 found;
      logic [TOTAL_W-1:0]   entry_total;
      logic [INDEX_W-1:0]   position;
      word_type             out_global;
      word_type             out_local_first;
      word_type             out_local_second;
   } rsp_type;

endpackage

/* hw/rtl/sukset_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted unique key set - channel interfaces
// Command channel and result channel, each a valid/ready pair with payload.
// ----------------------------------------------------------------------------
interface sukset_req_if;
   logic                              valid;
   logic                              ready;
   sukset_pkg::cmd_type               cmd;
   sukset_pkg::word_type              global_admin;
   sukset_pkg::word_type              local_first;
   sukset_pkg::word_type              local_second;
   logic [sukset_pkg::INDEX_W-1:0]    read_index;

   modport source (
      output valid, cmd, global_admin, local_first, local_second, read_index,
      input  ready
   );
   modport sink (
      input  valid, cmd, global_admin, local_first, local_second, read_index,
      output ready
   );
endinterface

interface sukset_rsp_if;
   logic                              valid;
   logic                              ready;
   sukset_pkg::status_type            status;
   logic                              found;
   logic [sukset_pkg::TOTAL_W-1:0]    entry_total;
   logic [sukset_pkg::INDEX_W-1:0]    position;
   sukset_pkg::word_type              out_global;
   sukset_pkg::word_type              out_local_first;
   sukset_pkg::word_type              out_local_second;

   modport source (
      output valid, status, found, entry_total, position,
             out_global, out_local_first, out_local_second,
      input  ready
   );
   modport sink (
      input  valid, status, found, entry_total, position,
             out_global, out_local_first, out_local_second,
      output ready
   );
endinterface

/* hw/rtl/sukset_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted unique key set - generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sukset_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/sukset_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted unique key set - sequencer
// Walks the key RAM one entry per cycle through a single 96-bit comparator
// to find the insertion point, then moves the tail up or down one entry per
// cycle through the RAM's read and write ports.
// ----------------------------------------------------------------------------
module sukset_seq #(
   parameter int CAPACITY = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  sukset_pkg::cmd_type               cmd,
   input  sukset_pkg::key_type               key,
   input  logic [sukset_pkg::INDEX_W-1:0]    read_index,
   output logic                              idle,
   output logic                              done,
   output sukset_pkg::rsp_type               result,
   output logic                              ram_wr_en,
   output logic [$clog2(CAPACITY)-1:0]       ram_wr_addr,
   output sukset_pkg::key_type               ram_wr_data,
   output logic [$clog2(CAPACITY)-1:0]       ram_rd_addr,
   input  sukset_pkg::key_type               ram_rd_data
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > sukset_pkg::INDEX_W) ? CW : sukset_pkg::INDEX_W;

   sukset_pkg::seq_state_type state_ff, state_in;
   sukset_pkg::cmd_type       cmd_ff, cmd_in;
   sukset_pkg::key_type       key_ff, key_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             idx_ff, idx_in;
   logic [CW-1:0]             left_ff, left_in;
   logic                      pend_ff, pend_in;
   logic [CW-1:0]             pend_addr_ff, pend_addr_in;
   logic [CW-1:0]             pos_ff, pos_in;
   sukset_pkg::status_type    status_ff, status_in;
   logic                      found_ff, found_in;
   sukset_pkg::key_type       words_ff, words_in;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sukset_pkg::SEQ_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      idx_ff       <= idx_in;
      left_ff      <= left_in;
      pend_addr_ff <= pend_addr_in;
      pos_ff       <= pos_in;
      status_ff    <= status_in;
      found_ff     <= found_in;
      words_ff     <= words_in;
   end

   // next state, RAM control and result bookkeeping
   always_comb begin
      logic          hit;
      logic          hit_eq;
      logic [CW-1:0] at;
      logic          up;

      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      left_in      = left_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      pos_in       = pos_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      words_in     = words_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = AW'(pend_addr_ff);
      ram_wr_data  = ram_rd_data;
      ram_rd_addr  = AW'(idx_ff);
      done         = 1'b0;
      hit          = 1'b0;
      hit_eq       = 1'b0;
      at           = count_ff;
      up           = (cmd_ff == sukset_pkg::CMD_INSERT);

      unique case (state_ff)
         sukset_pkg::SEQ_IDLE: begin
            // present the read address early so a read beat has data next cycle
            ram_rd_addr = AW'(read_index);
            if (start) begin
               cmd_in    = cmd;
               key_in    = key;
               status_in = sukset_pkg::ST_DONE;
               found_in  = 1'b0;
               pos_in    = '0;
               words_in  = '0;
               idx_in    = '0;
               pend_in   = 1'b0;
               case (cmd)
                  sukset_pkg::CMD_CLEAR: begin
                     count_in = '0;
                     state_in = sukset_pkg::SEQ_FINISH;
                  end
                  sukset_pkg::CMD_INSERT,
                  sukset_pkg::CMD_DELETE,
                  sukset_pkg::CMD_LOOKUP: begin
                     state_in = sukset_pkg::SEQ_SCAN;
                  end
                  sukset_pkg::CMD_READ: begin
                     if (CMPW'(read_index) < CMPW'(count_ff)) begin
                        state_in = sukset_pkg::SEQ_READ;
                     end else begin
                        status_in = sukset_pkg::ST_RANGE;
                        state_in  = sukset_pkg::SEQ_FINISH;
                     end
                  end
                  default: begin
                     state_in = sukset_pkg::SEQ_FINISH;
                  end
               endcase
            end
         end

         sukset_pkg::SEQ_READ: begin
            words_in = ram_rd_data;
            state_in = sukset_pkg::SEQ_FINISH;
         end

         sukset_pkg::SEQ_SCAN: begin
            // stop at the first entry not below the key, or at the end
            if (pend_ff && (ram_rd_data >= key_ff)) begin
               hit    = 1'b1;
               hit_eq = (ram_rd_data == key_ff);
               at     = pend_addr_ff;
            end else if (idx_ff == count_ff) begin
               hit = 1'b1;
            end else begin
               pend_in      = 1'b1;
               pend_addr_in = idx_ff;
               idx_in       = idx_ff + CW'(1);
            end

            if (hit) begin
               pend_in = 1'b0;
               case (cmd_ff)
                  sukset_pkg::CMD_INSERT: begin
                     if (hit_eq) begin
                        status_in = sukset_pkg::ST_DUPLICATE;
                        found_in  = 1'b1;
                        pos_in    = at;
                        state_in  = sukset_pkg::SEQ_FINISH;
                     end else if (count_ff == CW'(CAPACITY)) begin
                        status_in = sukset_pkg::ST_FULL;
                        state_in  = sukset_pkg::SEQ_FINISH;
                     end else begin
                        pos_in   = at;
                        idx_in   = count_ff - CW'(1);
                        left_in  = count_ff - at;
                        state_in = sukset_pkg::SEQ_SHIFT;
                     end
                  end
                  sukset_pkg::CMD_DELETE: begin
                     if (hit_eq) begin
                        found_in = 1'b1;
                        pos_in   = at;
                        idx_in   = at + CW'(1);
                        left_in  = count_ff - at - CW'(1);
                        state_in = sukset_pkg::SEQ_SHIFT;
                     end else begin
                        status_in = sukset_pkg::ST_NOT_FOUND;
                        state_in  = sukset_pkg::SEQ_FINISH;
                     end
                  end
                  default: begin
                     if (hit_eq) begin
                        found_in = 1'b1;
                        pos_in   = at;
                     end else begin
                        status_in = sukset_pkg::ST_NOT_FOUND;
                     end
                     state_in = sukset_pkg::SEQ_FINISH;
                  end
               endcase
            end
         end

         sukset_pkg::SEQ_SHIFT: begin
            // write back the entry read last cycle, one slot up or down
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = up ? AW'(pend_addr_ff + CW'(1)) : AW'(pend_addr_ff - CW'(1));
               ram_wr_data = ram_rd_data;
            end
            if (left_ff != '0) begin
               pend_in      = 1'b1;
               pend_addr_in = idx_ff;
               idx_in       = up ? (idx_ff - CW'(1)) : (idx_ff + CW'(1));
               left_in      = left_ff - CW'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  // tail moved: drop the new key into its slot or shrink
                  if (up) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = AW'(pos_ff);
                     ram_wr_data = key_ff;
                     count_in    = count_ff + CW'(1);
                  end else begin
                     count_in = count_ff - CW'(1);
                  end
                  state_in = sukset_pkg::SEQ_FINISH;
               end
            end
         end

         sukset_pkg::SEQ_FINISH: begin
            done     = 1'b1;
            state_in = sukset_pkg::SEQ_IDLE;
         end

         default: begin
            state_in = sukset_pkg::SEQ_IDLE;
         end
      endcase
   end

   assign idle = (state_ff == sukset_pkg::SEQ_IDLE);

   assign result.status           = status_ff;
   assign result.found            = found_ff;
   assign result.entry_total      = sukset_pkg::TOTAL_W'(count_ff);
   assign result.position         = sukset_pkg::INDEX_W'(pos_ff);
   assign result.out_global       = words_ff[3*sukset_pkg::WORD_W-1:2*sukset_pkg::WORD_W];
   assign result.out_local_first  = words_ff[2*sukset_pkg::WORD_W-1:sukset_pkg::WORD_W];
   assign result.out_local_second = words_ff[sukset_pkg::WORD_W-1:0];

endmodule

/* hw/rtl/sorted_unique_key_set.sv */
// Commands are taken one at a time: a new command is accepted only when the
// sequencer is idle and the result register is empty or its beat is being taken.
// A lookup, insert or delete scans up to the first entry not below the key, or to
// the end of the store. The scan and the tail move go one entry per cycle through
// the single read port of the key RAM. Reset returns the sequencer to idle, zeroes
// the entry count and drops any pending result beat; the stored keys stay.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted unique key set - top level
// Ordered set of 96-bit keys with insert, delete, lookup, read by index and
// clear; holds the key RAM, the sequencer and the result register.
// ----------------------------------------------------------------------------
module sorted_unique_key_set #(
   parameter int CAPACITY = 64
) (
   input  logic          clock,
   input  logic          reset,
   sukset_req_if.sink    req_chan,
   sukset_rsp_if.source  rsp_chan
);

   localparam int AW = $clog2(CAPACITY);

   logic                      seq_idle;
   logic                      seq_done;
   logic                      start;
   sukset_pkg::rsp_type       seq_result;
   logic                      ram_wr_en;
   logic [AW-1:0]             ram_wr_addr;
   sukset_pkg::key_type       ram_wr_data;
   logic [AW-1:0]             ram_rd_addr;
   sukset_pkg::key_type       ram_rd_data;
   logic                      rsp_vld_ff, rsp_vld_in;
   sukset_pkg::rsp_type       rsp_data_ff, rsp_data_in;

   // take a beat only when the result register will be free
   assign req_chan.ready = seq_idle && (!rsp_vld_ff || rsp_chan.ready);
   assign start          = req_chan.valid && req_chan.ready;

   sukset_seq #(
      .CAPACITY (CAPACITY)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .cmd         (req_chan.cmd),
      .key         ({req_chan.global_admin, req_chan.local_first, req_chan.local_second}),
      .read_index  (req_chan.read_index),
      .idle        (seq_idle),
      .done        (seq_done),
      .result      (seq_result),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   sukset_ram #(
      .WIDTH (sukset_pkg::KEY_W),
      .DEPTH (CAPACITY)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // load the result beat on completion, hold it until taken
   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      if (rsp_vld_ff && rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end
      if (seq_done) begin
         rsp_vld_in  = 1'b1;
         rsp_data_in = seq_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid            = rsp_vld_ff;
   assign rsp_chan.status           = rsp_data_ff.status;
   assign rsp_chan.found            = rsp_data_ff.found;
   assign rsp_chan.entry_total      = rsp_data_ff.entry_total;
   assign rsp_chan.position         = rsp_data_ff.position;
   assign rsp_chan.out_global       = rsp_data_ff.out_global;
   assign rsp_chan.out_local_first  = rsp_data_ff.out_local_first;
   assign rsp_chan.out_local_second = rsp_data_ff.out_local_second;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted unique key set - testbench
// Drives clear, insert, delete, lookup, read and unused command codes into
// the key set and checks every result against an in-bench model of the
// ordered store. Runs a short directed list, then four phases of random
// traffic under different idle and stall patterns; each phase first fills
// the store to capacity so the full-store path is exercised.
// ----------------------------------------------------------------------------
module testbench;

   localparam int                  STORE_DEPTH    = 64;
   localparam int                  PHASE_ITEMS    = 382;
   localparam int                  WATCHDOG_LIMIT = 4000;
   localparam int                  DRAIN_CYCLES   = 3 * STORE_DEPTH;
   localparam int                  MAX_PRINTED    = 40;
   localparam sukset_pkg::cmd_type CMD_TOP_CODE   = '1;

   typedef logic [sukset_pkg::INDEX_W-1:0] index_type;

   typedef struct {
      sukset_pkg::cmd_type   cmd;
      sukset_pkg::key_type   key;
      index_type             index;
   } key_cmd_type;

   // Ordered-store model plus the queue of responses it predicts
   class key_set_scoreboard;
      sukset_pkg::key_type stored[STORE_DEPTH];
      int unsigned         total;
      sukset_pkg::rsp_type pending_responses[$];
      int                  mismatches;
      int                  response_count;

      function new();
         total          = 0;
         mismatches     = 0;
         response_count = 0;
      endfunction

      function sukset_pkg::rsp_type predict_response(key_cmd_type c);
         sukset_pkg::rsp_type r;
         int unsigned         slot;
         int unsigned         i;
         bit                  hit;
         r = '0;
         // first slot not below the key
         slot = 0;
         while (slot < total && stored[slot] < c.key) slot++;
         hit = (slot < total) && (stored[slot] == c.key);
         case (c.cmd)
            sukset_pkg::CMD_CLEAR: begin
               total = 0;
            end
            sukset_pkg::CMD_INSERT: begin
               if (hit) begin
                  r.status   = sukset_pkg::ST_DUPLICATE;
                  r.found    = 1'b1;
                  r.position = slot[sukset_pkg::INDEX_W-1:0];
               end else if (total >= STORE_DEPTH) begin
                  r.status = sukset_pkg::ST_FULL;
               end else begin
                  // open a hole at the slot by moving the tail up
                  for (i = total; i > slot; i--) stored[i] = stored[i-1];
                  stored[slot] = c.key;
                  total++;
                  r.position = slot[sukset_pkg::INDEX_W-1:0];
               end
            end
            sukset_pkg::CMD_DELETE, sukset_pkg::CMD_LOOKUP: begin
               if (hit) begin
                  r.found    = 1'b1;
                  r.position = slot[sukset_pkg::INDEX_W-1:0];
                  if (c.cmd == sukset_pkg::CMD_DELETE) begin
                     // close the gap by moving the tail down
                     for (i = slot; i + 1 < total; i++) stored[i] = stored[i+1];
                     total--;
                  end
               end else begin
                  r.status = sukset_pkg::ST_NOT_FOUND;
               end
            end
            sukset_pkg::CMD_READ: begin
               if (c.index < total) begin
                  r.out_global       =
                     stored[c.index][sukset_pkg::KEY_W-1 -: sukset_pkg::WORD_W];
                  r.out_local_first  =
                     stored[c.index][2*sukset_pkg::WORD_W-1 -: sukset_pkg::WORD_W];
                  r.out_local_second = stored[c.index][sukset_pkg::WORD_W-1:0];
               end else begin
                  r.status = sukset_pkg::ST_RANGE;
               end
            end
            default: ;
         endcase
         r.entry_total = total[sukset_pkg::TOTAL_W-1:0];
         return r;
      endfunction

      function void note_command(key_cmd_type c);
         pending_responses.push_back(predict_response(c));
      endfunction

      task report_mismatch(string what, sukset_pkg::word_type got,
                           sukset_pkg::word_type want);
         mismatches++;
         if (mismatches <= MAX_PRINTED)
            $display("mismatch: response %0d %s got %h expected %h",
                     response_count, what, got, want);
      endtask

      task check_result(sukset_pkg::rsp_type got);
         sukset_pkg::rsp_type want;
         response_count++;
         if (pending_responses.size() == 0) begin
            report_mismatch("unexpected beat", '0, '0);
            return;
         end
         want = pending_responses.pop_front();
         if (got.status !== want.status)
            report_mismatch("status", sukset_pkg::word_type'(got.status),
                            sukset_pkg::word_type'(want.status));
         if (got.found !== want.found)
            report_mismatch("found", sukset_pkg::word_type'(got.found),
                            sukset_pkg::word_type'(want.found));
         if (got.entry_total !== want.entry_total)
            report_mismatch("entry_total", sukset_pkg::word_type'(got.entry_total),
                            sukset_pkg::word_type'(want.entry_total));
         if (got.position !== want.position)
            report_mismatch("position", sukset_pkg::word_type'(got.position),
                            sukset_pkg::word_type'(want.position));
         if (got.out_global !== want.out_global)
            report_mismatch("out_global", got.out_global, want.out_global);
         if (got.out_local_first !== want.out_local_first)
            report_mismatch("out_local_first", got.out_local_first, want.out_local_first);
         if (got.out_local_second !== want.out_local_second)
            report_mismatch("out_local_second", got.out_local_second, want.out_local_second);
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   sukset_req_if req_bus ();
   sukset_rsp_if rsp_bus ();

   key_set_scoreboard sb = new();

   int src_idle_pct  = 0;
   int snk_stall_pct = 0;
   int items_sent    = 0;
   int idle_cycles   = 0;

   sorted_unique_key_set #(
      .CAPACITY (STORE_DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Keys that often share leading words, so every word of the compare matters
   function automatic sukset_pkg::key_type make_key();
      sukset_pkg::word_type w[3];
      for (int k = 0; k < 3; k++) begin
         case ($urandom_range(3))
            0, 1: w[k] = $urandom();
            2: w[k] = $urandom_range(3);
            default: w[k] = 32'hFFFF_FFFF - $urandom_range(1);
         endcase
      end
      return {w[0], w[1], w[2]};
   endfunction

   function automatic sukset_pkg::key_type stored_or_new_key(int pct_stored);
      if (sb.total > 0 && $urandom_range(99) < pct_stored)
         return sb.stored[$urandom_range(sb.total - 1)];
      return make_key();
   endfunction

   // One random command, biased toward keys currently held
   function automatic key_cmd_type pick_command();
      key_cmd_type c;
      int          roll;
      roll    = $urandom_range(99);
      c.key   = make_key();
      c.index = index_type'($urandom());
      if (roll < 35) begin
         c.cmd = sukset_pkg::CMD_INSERT;
         c.key = stored_or_new_key(30);
      end else if (roll < 55) begin
         c.cmd = sukset_pkg::CMD_DELETE;
         c.key = stored_or_new_key(70);
      end else if (roll < 75) begin
         c.cmd = sukset_pkg::CMD_LOOKUP;
         c.key = stored_or_new_key(70);
      end else if (roll < 92) begin
         c.cmd = sukset_pkg::CMD_READ;
         if ($urandom_range(3) != 0) c.index = index_type'($urandom_range(sb.total));
      end else if (roll < 94) begin
         c.cmd = sukset_pkg::CMD_CLEAR;
      end else begin
         c.cmd = sukset_pkg::cmd_type'($urandom_range(sukset_pkg::CMD_READ + 1,
                                                      CMD_TOP_CODE));
      end
      return c;
   endfunction

   // Present one beat, with random idle cycles ahead of it; call at a falling edge
   task send_command(key_cmd_type c);
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.cmd          <= c.cmd;
      req_bus.global_admin <= c.key[sukset_pkg::KEY_W-1 -: sukset_pkg::WORD_W];
      req_bus.local_first  <= c.key[2*sukset_pkg::WORD_W-1 -: sukset_pkg::WORD_W];
      req_bus.local_second <= c.key[sukset_pkg::WORD_W-1:0];
      req_bus.read_index   <= c.index;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task issue(sukset_pkg::cmd_type cmd, sukset_pkg::key_type key, int index);
      key_cmd_type c;
      c.cmd   = cmd;
      c.key   = key;
      c.index = index_type'(index);
      send_command(c);
   endtask

   // Receiver stalls
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
   end

   // Track accepted commands and check accepted results
   always @(posedge clock) begin : monitor
      key_cmd_type         c;
      sukset_pkg::rsp_type got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            c.cmd   = req_bus.cmd;
            c.key   = {req_bus.global_admin, req_bus.local_first, req_bus.local_second};
            c.index = req_bus.read_index;
            sb.note_command(c);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.status           = rsp_bus.status;
            got.found            = rsp_bus.found;
            got.entry_total      = rsp_bus.entry_total;
            got.position         = rsp_bus.position;
            got.out_global       = rsp_bus.out_global;
            got.out_local_first  = rsp_bus.out_local_first;
            got.out_local_second = rsp_bus.out_local_second;
            sb.check_result(got);
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // Watchdog on cycles without any accepted beat
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL sorted_unique_key_set");
      $finish;
   end

   initial begin : stimulus
      int guard;
      int phase_end;
      req_bus.valid        = 1'b0;
      req_bus.cmd          = sukset_pkg::CMD_CLEAR;
      req_bus.global_admin = '0;
      req_bus.local_first  = '0;
      req_bus.local_second = '0;
      req_bus.read_index   = '0;
      rsp_bus.ready        = 1'b0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty store, ordering on each key word, extremes, unused codes
      issue(sukset_pkg::CMD_READ,   '0, 0);
      issue(sukset_pkg::CMD_LOOKUP, '0, 0);
      issue(sukset_pkg::CMD_DELETE, '1, 0);
      issue(sukset_pkg::CMD_INSERT, {32'd1, 32'd1, 32'd1}, 0);
      issue(sukset_pkg::CMD_INSERT, '1, 63);
      issue(sukset_pkg::CMD_INSERT, '0, 0);
      issue(sukset_pkg::CMD_INSERT, {32'd1, 32'd1, 32'd0}, 0);
      issue(sukset_pkg::CMD_INSERT, {32'd1, 32'd0, 32'hFFFF_FFFF}, 0);
      issue(sukset_pkg::CMD_INSERT, {32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 0);
      issue(sukset_pkg::CMD_INSERT, {32'd1, 32'd1, 32'd1}, 0);
      issue(sukset_pkg::CMD_LOOKUP, '1, 0);
      issue(sukset_pkg::CMD_READ,   '1, 0);
      issue(sukset_pkg::CMD_READ,   '0, 5);
      issue(sukset_pkg::CMD_READ,   '0, 6);
      issue(sukset_pkg::CMD_READ,   '0, 63);
      issue(sukset_pkg::CMD_DELETE, {32'd1, 32'd1, 32'd0}, 0);
      issue(sukset_pkg::CMD_DELETE, '0, 0);
      issue(sukset_pkg::CMD_DELETE, '1, 0);
      issue(sukset_pkg::CMD_LOOKUP, {32'd1, 32'd1, 32'd1}, 0);
      issue(sukset_pkg::CMD_READ + 3'd1, '1, 63);
      issue(sukset_pkg::CMD_READ + 3'd2, {32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555}, 42);
      issue(CMD_TOP_CODE, '1, 21);
      issue(sukset_pkg::CMD_CLEAR,  '1, 63);
      issue(sukset_pkg::CMD_READ,   '0, 0);
      issue(sukset_pkg::CMD_INSERT, '0, 0);

      // random phases: none, sender idle, receiver stall, both
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 75; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 75; end
            default: begin src_idle_pct = 35; snk_stall_pct = 35; end
         endcase
         phase_end = items_sent + PHASE_ITEMS;

         // fill the store, then hit it with a new key and a duplicate
         issue(sukset_pkg::CMD_CLEAR, make_key(), $urandom());
         guard = 0;
         while (sb.total < STORE_DEPTH && guard < 4 * STORE_DEPTH) begin
            issue(sukset_pkg::CMD_INSERT, make_key(), $urandom());
            guard++;
         end
         issue(sukset_pkg::CMD_INSERT, make_key(), $urandom());
         issue(sukset_pkg::CMD_INSERT, stored_or_new_key(100), $urandom());
         issue(sukset_pkg::CMD_READ, make_key(), STORE_DEPTH - 1);

         while (items_sent < phase_end) send_command(pick_command());
      end
      req_bus.valid <= 1'b0;

      // drain
      while (sb.pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending_responses.size() == 0) begin
         $display("PASS sorted_unique_key_set");
      end else begin
         $display("FAIL sorted_unique_key_set");
      end
      $finish;
   end

endmodule
